// ----- hw/rtl/dpad_key_repeat_engine_assert.svh -----
// Assertion macros for the d-pad key repeat engine
`ifndef DPAD_KEY_REPEAT_ENGINE_ASSERT_SVH
`define DPAD_KEY_REPEAT_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define DKRE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define DKRE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DKRE_ASSERT_ALWAYS(lbl, cond, msg)
`define DKRE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/dkre_pkg.sv -----
// Types and constants shared by the d-pad key repeat engine
package dkre_pkg;

    localparam int TIME_W     = 32;
    localparam int KEY_CODE_W = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    typedef logic [TIME_W-1:0] t_time;

    // input item kinds
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0]  REG_REPEAT_DELAY    = 4'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_REPEAT_INTERVAL = 4'd1;
    localparam logic [CFG_DATA_W-1:0] RST_REPEAT_DELAY    = 8'd15;
    localparam logic [CFG_DATA_W-1:0] RST_REPEAT_INTERVAL = 8'd5;

    typedef struct packed {
        logic                  kind;
        logic [KEY_CODE_W-1:0] key_code;
        logic                  key_press;
        logic                  key_up;
        logic                  is_repeat;
        logic                  is_dpad;
    } t_in_item;

    typedef struct packed {
        logic [KEY_CODE_W-1:0] move_key;
        logic                  repeated;
        logic                  table_full;
        logic                  last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_wr;

    // operation broadcast to every cell of the held-key chain
    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_INSERT,
        CELL_DELETE,
        CELL_MARK,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_time    trig;   // trigger time for an inserted key
        t_time    frame;  // current frame for the due check
    } t_cell_cmd;

    typedef struct packed {
        logic gt;         // empty, or key above the command key
        logic match;      // holds the command key
        logic pend_rest;  // due flag here or anywhere to the right
    } t_cell_stat;

endpackage

// ----- hw/rtl/dkre_if.sv -----
// Handshake channels of the d-pad key repeat engine: input, result and config write

interface dkre_in_if import dkre_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dkre_out_if import dkre_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dkre_cfg_if import dkre_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dkre_cell.sv -----
// One held-key cell of the sorted chain: key, trigger time, valid and due flag
module dkre_cell import dkre_pkg::*; #(
    parameter int KEY_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_cmd           i_cmd,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_left_gt,
    input  logic                i_left_valid,
    input  logic [KEY_BITS-1:0] i_left_key,
    input  t_time               i_left_trig,
    input  logic                i_right_valid,
    input  logic [KEY_BITS-1:0] i_right_key,
    input  t_time               i_right_trig,
    input  logic                i_right_pend,
    input  logic                i_right_pend_rest,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_key,
    output t_time               o_trig,
    output logic                o_pend,
    output t_cell_stat          o_stat
);

    logic                r_valid, n_valid;
    logic                r_pend,  n_pend;
    logic [KEY_BITS-1:0] r_key,   n_key;
    t_time               r_trig,  n_trig;
    t_time               w_diff;
    logic                w_gt;
    logic                w_match;

    // local compares against the broadcast key and frame
    assign w_gt    = !r_valid || (r_key > i_key);
    assign w_match = r_valid && (r_key == i_key);
    assign w_diff  = r_trig - i_cmd.frame;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_trig  = r_trig;
        n_pend  = r_pend;
        case (i_cmd.op)
            CELL_INSERT: begin
                // entries above the new key move one cell right
                if (i_left_gt) begin
                    n_valid = i_left_valid;
                    n_key   = i_left_key;
                    n_trig  = i_left_trig;
                    n_pend  = 1'b0;
                end else if (w_gt) begin
                    n_valid = 1'b1;
                    n_key   = i_key;
                    n_trig  = i_cmd.trig;
                    n_pend  = 1'b0;
                end
            end
            CELL_DELETE: begin
                // the matching entry and all above it close the gap
                if (w_gt || w_match) begin
                    n_valid = i_right_valid;
                    n_key   = i_right_key;
                    n_trig  = i_right_trig;
                    n_pend  = i_right_pend;
                end
            end
            CELL_MARK: begin
                n_pend = r_valid && w_diff[TIME_W-1];
            end
            CELL_ROTATE: begin
                n_valid = i_right_valid;
                n_key   = i_right_key;
                n_trig  = i_right_trig;
                n_pend  = i_right_pend;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
        r_key  <= n_key;
        r_trig <= n_trig;
    end

    assign o_valid          = r_valid;
    assign o_key            = r_key;
    assign o_trig           = r_trig;
    assign o_pend           = r_pend;
    assign o_stat.gt        = w_gt;
    assign o_stat.match     = w_match;
    assign o_stat.pend_rest = r_pend || i_right_pend_rest;

endmodule

// ----- hw/rtl/dpad_key_repeat_engine.sv -----
// Top level of the d-pad key repeat engine: held-key cell chain and sequencer
//
//   channel  dir  modport  carries
//   i_in     in   sink     key event or frame tick
//   o_out    out  source   focus move (key, repeated, table_full, last)
//   i_cfg    in   sink     register write (index, value)
//
// On a key event, lookup, insert and delete run in parallel in
// all cells; if the output register is still full, input stays blocked until
// its move is loaded. A frame tick first counts the frame, then marks due keys,
// then rotates the chain once per cell, the head cell emitting its key when
// due. A due head waits while a result sits in the output register. Reset
// clears every cell's valid flag at once.
`include "dpad_key_repeat_engine_assert.svh"

module dpad_key_repeat_engine import dkre_pkg::*; #(
    parameter int HELD_SLOTS = 8,
    parameter int KEY_BITS   = 10
) (
    input logic          i_clk,
    input logic          i_rst_n,
    dkre_in_if.sink      i_in,
    dkre_out_if.source   o_out,
    dkre_cfg_if.sink     i_cfg
);

    localparam int N     = HELD_SLOTS;
    localparam int CNT_W = (N > 1) ? $clog2(N) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_SCAN,
        S_PEND
    } t_state;

    t_state                r_state, n_state;
    t_time                 r_frame_now, n_frame_now;
    t_time                 r_resched, n_resched;
    logic [CFG_DATA_W-1:0] r_delay, n_delay;
    logic [CFG_DATA_W-1:0] r_interval, n_interval;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [KEY_CODE_W-1:0] r_out_key, n_out_key;
    logic                  r_out_rep, n_out_rep;
    logic                  r_out_full, n_out_full;
    logic                  r_out_last, n_out_last;
    logic [KEY_CODE_W-1:0] r_evt_key, n_evt_key;
    logic                  r_evt_full, n_evt_full;

    // chain arrays: index 0 is the pad left of the head, N+1 the tail feed
    logic                e_valid     [0:N+1];
    logic [KEY_BITS-1:0] e_key       [0:N+1];
    t_time               e_trig      [0:N+1];
    logic                e_pend      [0:N+1];
    logic                e_pend_rest [0:N+1];
    logic                e_gt        [0:N];
    t_cell_stat          w_stat      [0:N-1];
    logic [N-1:0]        w_match;
    logic [N-1:0]        w_valid_vec;
    logic [N-1:0]        w_pend_vec;
    logic [N:0]          w_valid_inc;

    t_cell_cmd             w_cmd;
    logic [KEY_BITS-1:0]   w_key_in;
    logic [KEY_CODE_W-1:0] w_evt_key10;
    logic [KEY_CODE_W-1:0] w_head_key10;
    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_hit;
    logic                  w_full;
    logic                  w_press;
    logic                  w_rot;

    // key code masked to KEY_BITS, and held keys widened back to the port
    for (genvar b = 0; b < KEY_BITS; b++) begin : g_key_in
        if (b < KEY_CODE_W) begin : g_bit
            assign w_key_in[b] = i_in.data.key_code[b];
        end else begin : g_zero
            assign w_key_in[b] = 1'b0;
        end
    end
    for (genvar b = 0; b < KEY_CODE_W; b++) begin : g_key_out
        if (b < KEY_BITS) begin : g_bit
            assign w_evt_key10[b]  = i_in.data.key_code[b];
            assign w_head_key10[b] = e_key[1][b];
        end else begin : g_zero
            assign w_evt_key10[b]  = 1'b0;
            assign w_head_key10[b] = 1'b0;
        end
    end

    // pads at both ends of the chain
    assign e_valid[0]     = 1'b0;
    assign e_key[0]       = '0;
    assign e_trig[0]      = '0;
    assign e_pend[0]      = 1'b0;
    assign e_pend_rest[0] = 1'b0;
    assign e_gt[0]        = 1'b0;

    // tail feed: the head wraps around on rotation, otherwise an empty entry
    assign w_rot            = (w_cmd.op == CELL_ROTATE);
    assign e_valid[N+1]     = w_rot ? e_valid[1] : 1'b0;
    assign e_key[N+1]       = w_rot ? e_key[1] : '0;
    assign e_trig[N+1]      = (w_rot && e_pend[1]) ? r_resched :
                              (w_rot ? e_trig[1] : '0);
    assign e_pend[N+1]      = 1'b0;
    assign e_pend_rest[N+1] = 1'b0;

    // chain of held-key cells, kept sorted by key with entries packed at the head
    for (genvar i = 0; i < N; i++) begin : g_cell
        dkre_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_cmd             (w_cmd),
            .i_key             (w_key_in),
            .i_left_gt         (e_gt[i]),
            .i_left_valid      (e_valid[i]),
            .i_left_key        (e_key[i]),
            .i_left_trig       (e_trig[i]),
            .i_right_valid     (e_valid[i+2]),
            .i_right_key       (e_key[i+2]),
            .i_right_trig      (e_trig[i+2]),
            .i_right_pend      (e_pend[i+2]),
            .i_right_pend_rest (e_pend_rest[i+2]),
            .o_valid           (e_valid[i+1]),
            .o_key             (e_key[i+1]),
            .o_trig            (e_trig[i+1]),
            .o_pend            (e_pend[i+1]),
            .o_stat            (w_stat[i])
        );
        assign e_gt[i+1]        = w_stat[i].gt;
        assign e_pend_rest[i+1] = w_stat[i].pend_rest;
        assign w_match[i]       = w_stat[i].match;
        assign w_valid_vec[i]   = e_valid[i+1];
        assign w_pend_vec[i]    = e_pend[i+1];
    end

    assign w_valid_inc = {1'b0, w_valid_vec} + (N+1)'(1);

    // handshake and event decode
    assign w_in_acc   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_hit      = |w_match;
    assign w_full     = e_valid[N];
    assign w_press    = i_in.data.key_press && !i_in.data.is_repeat && i_in.data.is_dpad;

    always_comb begin
        n_state     = r_state;
        n_frame_now = r_frame_now;
        n_resched   = r_resched;
        n_delay     = r_delay;
        n_interval  = r_interval;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_key   = r_out_key;
        n_out_rep   = r_out_rep;
        n_out_full  = r_out_full;
        n_out_last  = r_out_last;
        n_evt_key   = r_evt_key;
        n_evt_full  = r_evt_full;
        w_cmd.op    = CELL_NOP;
        w_cmd.trig  = r_frame_now + {{(TIME_W-CFG_DATA_W){1'b0}}, r_delay};
        w_cmd.frame = r_frame_now;

        // register writes
        if (i_cfg.valid) begin
            if (i_cfg.data.index == REG_REPEAT_DELAY) begin
                n_delay = i_cfg.data.value;
            end else if (i_cfg.data.index == REG_REPEAT_INTERVAL) begin
                n_interval = i_cfg.data.value;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.data.kind == KIND_TICK) begin
                        n_frame_now = r_frame_now + TIME_W'(1);
                        n_state     = S_MARK;
                    end else begin
                        // press then release: a fresh key released at once is not kept
                        if (i_in.data.key_up && w_hit) begin
                            w_cmd.op = CELL_DELETE;
                        end else if (w_press && !w_hit && !w_full && !i_in.data.key_up) begin
                            w_cmd.op = CELL_INSERT;
                        end
                        if (w_press && !w_hit) begin
                            if (w_out_free) begin
                                n_out_valid = 1'b1;
                                n_out_key   = w_evt_key10;
                                n_out_rep   = 1'b0;
                                n_out_full  = w_full;
                                n_out_last  = 1'b1;
                            end else begin
                                n_evt_key  = w_evt_key10;
                                n_evt_full = w_full;
                                n_state    = S_PEND;
                            end
                        end
                    end
                end
            end
            S_MARK: begin
                w_cmd.op  = CELL_MARK;
                n_resched = r_frame_now + {{(TIME_W-CFG_DATA_W){1'b0}}, r_interval};
                n_cnt     = '0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                // one rotation per cycle; a due head waits for the output register
                if (!e_pend[1] || w_out_free) begin
                    w_cmd.op = CELL_ROTATE;
                    if (e_pend[1]) begin
                        n_out_valid = 1'b1;
                        n_out_key   = w_head_key10;
                        n_out_rep   = 1'b1;
                        n_out_full  = 1'b0;
                        n_out_last  = !e_pend_rest[2];
                    end
                    n_cnt = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(N - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PEND: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_key   = r_evt_key;
                    n_out_rep   = 1'b0;
                    n_out_full  = r_evt_full;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frame_now <= '0;
            r_delay     <= RST_REPEAT_DELAY;
            r_interval  <= RST_REPEAT_INTERVAL;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frame_now <= n_frame_now;
            r_delay     <= n_delay;
            r_interval  <= n_interval;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_resched  <= n_resched;
        r_out_key  <= n_out_key;
        r_out_rep  <= n_out_rep;
        r_out_full <= n_out_full;
        r_out_last <= n_out_last;
        r_evt_key  <= n_evt_key;
        r_evt_full <= n_evt_full;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_out.valid           = r_out_valid;
    assign o_out.data.move_key   = r_out_key;
    assign o_out.data.repeated   = r_out_rep;
    assign o_out.data.table_full = r_out_full;
    assign o_out.data.last       = r_out_last;

    // held entries sit packed at the head whenever the chain is at rest
    `DKRE_ASSERT_ALWAYS(a_chain_packed, (r_state != S_IDLE) || ((w_valid_vec & w_valid_inc[N-1:0]) == '0), "held keys not packed at chain head")
    // every due key of a tick has been emitted before the next item
    `DKRE_ASSERT_ALWAYS(a_no_due_left, (r_state != S_IDLE) || (w_pend_vec == '0), "due flag left after tick")
    // the frame counter moves only on an accepted tick
    `DKRE_ASSERT_NEXT(a_frame_hold, !(w_in_acc && (i_in.data.kind == KIND_TICK)), $stable(r_frame_now), "frame counter moved without a tick")

endmodule
